// ===== hw/rtl/hce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types and constants of the Huffman code emitter: opcodes, field
// widths, code table geometry and the byte job that the packer hands to the
// output queue.
// ----------------------------------------------------------------------------
package hce_pkg;

	// opcodes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_EMIT   = 2'd2;
	localparam logic [1:0] OP_FLUSH  = 2'd3;

	// code table geometry
	localparam int SYMBOL_COUNT = 65536;
	localparam int SYM_W        = 16;
	localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int MAX_CODE_LEN = 32;

	// field widths
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;

	// bit packer: up to seven pending bits plus one full code word
	localparam int PEND_W = 7;
	localparam int PCNT_W = 3;
	localparam int ACC_W  = PEND_W + CODE_W;
	localparam int JOB_BYTES = 4;
	localparam int JOB_W  = JOB_BYTES * BYTE_W;
	localparam int JCNT_W = 3;

	// table entry: code word above its length
	localparam int ENTRY_W = CODE_W + LEN_W;

	// output job queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// completed bytes of one item, left-aligned, first byte on top
	typedef struct packed {
		logic [JOB_W-1:0]  word;
		logic [JCNT_W-1:0] nbytes;
		logic              err;
	} hce_job_t;

endpackage

// ===== hw/rtl/huffman_code_emitter.sv =====
`timescale 1ns / 1ps
// An accepted item passes the stage 1 registers and table read, the job queue
// and the serializer register before its first byte is on the output.
// The packer takes one item per cycle while in_stall is low; bytes leave one
// per cycle while out_stall is low, so an item holds the output for all its bytes.
// Input stalls when the four-entry job queue has no room reserved.
// Reset: a clearing pass writes all 65536 table entries, one per cycle,
// with in_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// huffman_code_emitter
// Code table in one synchronous memory, a one-stage bit packer and a queued
// byte serializer. Loads write the table, encodes read it, emits and flushes
// go straight to the packer.
// ----------------------------------------------------------------------------
module huffman_code_emitter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         stream_half,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic [hce_pkg::SYM_W-1:0]    table_index,
	input  logic [hce_pkg::CODE_W-1:0]   code_bits,
	input  logic [hce_pkg::LEN_W-1:0]    code_length,
	input  logic [hce_pkg::WORD_W-1:0]   symbol_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hce_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last,
	output logic                         code_error
);
	import hce_pkg::*;

	localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_LEN);

	logic [ENTRY_W-1:0] tbl_mem [SYMBOL_COUNT];
	logic [ENTRY_W-1:0] rd_q;

	logic               stream_half_q;
	logic               clr_active_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	logic               accept;
	logic [SYM_W-1:0]   sym;
	logic [LEN_W-1:0]   len_clamp;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [CODE_W-1:0]  bits_s1;
	logic [LEN_W-1:0]   len_s1;
	logic               sym_ok_s1;

	logic [PEND_W-1:0]  pend_q;
	logic [PCNT_W-1:0]  pcnt_q;

	logic [CODE_W-1:0]  src_bits;
	logic [LEN_W-1:0]   src_len;
	logic [ACC_W-1:0]   mask;
	logic [ACC_W-1:0]   acc;
	logic [LEN_W-1:0]   total;
	logic [JCNT_W-1:0]  nbytes;
	logic [PCNT_W-1:0]  rem;
	logic [ACC_W-1:0]   full;
	logic [JOB_W-1:0]   aligned;
	logic [BYTE_W-1:0]  flush_byte;

	logic               push;
	hce_job_t           push_job;
	logic               pend_upd;
	logic [PEND_W-1:0]  pend_d;
	logic [PCNT_W-1:0]  pcnt_d;
	logic [Q_CW-1:0]    q_count;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_half_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			stream_half_q <= stream_half;
		end
	end

	// table clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(SYMBOL_COUNT - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// input handshake with room reserved in the job queue
	assign in_stall = clr_active_q || ((Q_CW + 1)'(q_count) + (Q_CW + 1)'(valid_s1)
		>= (Q_CW + 1)'(Q_DEPTH));
	assign accept   = in_valid && !in_stall;

	assign sym       = stream_half_q ? symbol_word[WORD_W-1 -: SYM_W] : symbol_word[SYM_W-1:0];
	assign len_clamp = (code_length > LEN_MAX) ? LEN_MAX : code_length;

	// table write port: clearing pass or load
	always_comb begin
		if (clr_active_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = accept && (opcode == OP_LOAD) && ({1'b0, table_index} < SYM_LIMIT);
			mem_waddr = table_index[ADDR_W-1:0];
			mem_wdata = {code_bits, len_clamp};
		end
	end

	// code table memory with a registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_waddr] <= mem_wdata;
		end
		if (accept && opcode == OP_ENCODE) begin
			rd_q <= tbl_mem[sym[ADDR_W-1:0]];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= opcode;
			bits_s1   <= code_bits;
			len_s1    <= len_clamp;
			sym_ok_s1 <= ({1'b0, sym} < SYM_LIMIT);
		end
	end

	// bit source: table entry for encode, raw bits for emit
	assign src_bits = (op_s1 == OP_ENCODE) ? rd_q[ENTRY_W-1 -: CODE_W] : bits_s1;
	assign src_len  = (op_s1 == OP_ENCODE) ? rd_q[LEN_W-1:0] : len_s1;

	// append to the pending bits and split off completed bytes
	assign mask    = ~({ACC_W{1'b1}} << src_len);
	assign acc     = (ACC_W'(pend_q) << src_len) | (ACC_W'(src_bits) & mask);
	assign total   = LEN_W'(pcnt_q) + src_len;
	assign nbytes  = total[LEN_W-1:PCNT_W];
	assign rem     = total[PCNT_W-1:0];
	assign full    = acc >> rem;
	assign aligned = full[JOB_W-1:0] << {(JCNT_W'(JOB_BYTES) - nbytes), 3'b000};

	// pending bits padded with zeros below
	assign flush_byte = BYTE_W'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));

	// packer step
	always_comb begin
		push          = 1'b0;
		push_job      = '0;
		pend_upd      = 1'b0;
		pend_d        = pend_q;
		pcnt_d        = pcnt_q;
		if (valid_s1) begin
			case (op_s1)
				OP_ENCODE, OP_EMIT: begin
					if (op_s1 == OP_ENCODE && (!sym_ok_s1 || src_len == '0)) begin
						// symbol without a code: one error result
						push            = 1'b1;
						push_job.nbytes = JCNT_W'(1);
						push_job.err    = 1'b1;
					end else begin
						push            = (nbytes != '0);
						push_job.word   = aligned;
						push_job.nbytes = nbytes;
						pend_upd        = 1'b1;
						pend_d          = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
						pcnt_d          = rem;
					end
				end
				OP_FLUSH: begin
					push            = (pcnt_q != '0);
					push_job.word   = {flush_byte, (JOB_W - BYTE_W)'(0)};
					push_job.nbytes = JCNT_W'(1);
					pend_upd        = 1'b1;
					pend_d          = '0;
					pcnt_d          = '0;
				end
				default: begin
					pend_upd = 1'b0;
				end
			endcase
		end
	end

	// packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (pend_upd) begin
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
		end
	end

	// job queue and byte serializer
	hce_byte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.q_count    (q_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last),
		.code_error (code_error)
	);

endmodule

// ===== hw/rtl/hce_byte_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hce_byte_queue
// Small job queue plus byte serializer. Each job holds one to four completed
// bytes (or one error result); bytes leave one per cycle while out_stall is
// low, last marks the final byte of a job.
// ----------------------------------------------------------------------------
module hce_byte_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  hce_pkg::hce_job_t            push_job,
	output logic [hce_pkg::Q_CW-1:0]     q_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hce_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last,
	output logic                         code_error
);
	import hce_pkg::*;

	hce_job_t             q_mem [Q_DEPTH];
	logic [Q_AW-1:0]      wr_ptr_q;
	logic [Q_AW-1:0]      rd_ptr_q;
	logic [Q_CW-1:0]      cnt_q;
	logic                 cur_valid_q;
	logic [JOB_W-1:0]     cur_word_q;
	logic [JCNT_W-1:0]    cur_left_q;
	logic                 cur_err_q;
	logic                 take;
	logic                 pop;

	// handshake on the result side
	assign take = cur_valid_q && !out_stall;
	assign pop  = (cnt_q != '0) && (!cur_valid_q || (take && cur_left_q == JCNT_W'(1)));

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_job;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + Q_CW'(1);
				2'b01:   cnt_q <= cnt_q - Q_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_left_q  <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			cur_left_q  <= q_mem[rd_ptr_q].nbytes;
		end else if (take) begin
			if (cur_left_q == JCNT_W'(1)) begin
				cur_valid_q <= 1'b0;
			end
			cur_left_q <= cur_left_q - JCNT_W'(1);
		end
	end

	// serializer payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_word_q <= q_mem[rd_ptr_q].word;
			cur_err_q  <= q_mem[rd_ptr_q].err;
		end else if (take) begin
			cur_word_q <= {cur_word_q[JOB_W-BYTE_W-1:0], BYTE_W'(0)};
		end
	end

	assign q_count    = cnt_q;
	assign out_valid  = cur_valid_q;
	assign out_byte   = cur_err_q ? '0 : cur_word_q[JOB_W-1 -: BYTE_W];
	assign last       = (cur_left_q == JCNT_W'(1));
	assign code_error = cur_err_q;

endmodule

// ===== hw/rtl/hce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hce_checker
// Port-level checks of the Huffman code emitter: held result items while
// stalled, the shape of error results and the input stall after reset.
// ----------------------------------------------------------------------------
module hce_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [hce_pkg::BYTE_W-1:0]  out_byte,
	input logic                        last,
	input logic                        code_error
);
	import hce_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last)
		&& $stable(code_error))
		else $error("result item changed while stalled");

	// an error result is a single item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_error |-> last)
		else $error("error result not marked last");

	// an error result carries no byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_error |-> out_byte == '0)
		else $error("error result with nonzero byte");

	// no input taken in the first cycle after reset (table clearing)
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input accepted during table clearing");

endmodule

bind huffman_code_emitter hce_checker u_hce_checker (.*);
